// ===== rtl/encoder_count_velocity_monitor_top_macros.svh =====
// Assertion macros used by the checker file of the encoder velocity monitor.
`ifndef ENCODER_COUNT_VELOCITY_MONITOR_TOP_MACROS_SVH
`define ENCODER_COUNT_VELOCITY_MONITOR_TOP_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define ECVM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on aclk, off during reset.
`define ECVM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ecvm_pkg.sv =====
// Shared types, constants and register indexes of the encoder velocity monitor.
package ecvm_pkg;

    typedef struct packed {
        logic signed [31:0] count_a;
        logic signed [31:0] count_b;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] velocity_a;
        logic signed [15:0] velocity_b;
        logic               overflow_a;
        logic               underflow_a;
        logic               overflow_b;
        logic               underflow_b;
        logic               count_reached;
        logic               velocity_reached;
    } out_beat_t;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t CFG_IRQ_ENABLES       = 3'd0;
    localparam cfg_addr_t CFG_TARGET_COUNT_A    = 3'd1;
    localparam cfg_addr_t CFG_TARGET_COUNT_B    = 3'd2;
    localparam cfg_addr_t CFG_TARGET_VELOCITY_A = 3'd3;
    localparam cfg_addr_t CFG_TARGET_VELOCITY_B = 3'd4;
    localparam cfg_addr_t CFG_RATIO_LIMIT_A     = 3'd5;
    localparam cfg_addr_t CFG_RATIO_LIMIT_B     = 3'd6;

    localparam logic signed [31:0] REACH_WINDOW = 32'sd10;
    localparam logic signed [31:0] JUMP_LIMIT   = 32'sd30000;

    // Shared unit operations
    typedef logic [0:0] alu_op_t;
    localparam alu_op_t ALU_SUB = 1'b0;
    localparam alu_op_t ALU_MUL = 1'b1;

    localparam int ALU_OPND_W = 33;
    localparam int ALU_RES_W  = 64;

    typedef struct packed {
        alu_op_t                       op;
        logic signed [ALU_OPND_W-1:0]  a;
        logic signed [ALU_OPND_W-1:0]  b;
    } alu_req_t;

endpackage

// ===== rtl/ecvm_alu.sv =====
// Shared subtract / multiply unit with a registered result.
module ecvm_alu
    import ecvm_pkg::*;
(
    input  logic                 aclk,
    input  alu_req_t             req,
    output logic [ALU_RES_W-1:0] res_reg
);

    logic signed [ALU_OPND_W:0] diff;

    assign diff = {req.a[ALU_OPND_W-1], req.a} - {req.b[ALU_OPND_W-1], req.b};

    always_ff @(posedge aclk) begin
        case (req.op)
            ALU_SUB: begin
                res_reg <= {{(ALU_RES_W-ALU_OPND_W-1){diff[ALU_OPND_W]}}, diff};
            end
            ALU_MUL: begin
                // unsigned 32x32
                res_reg <= req.a[31:0] * req.b[31:0];
            end
            default: begin
                res_reg <= '0;
            end
        endcase
    end

endmodule

// ===== rtl/encoder_count_velocity_monitor_top.sv =====
// Top level of the two-channel encoder count and velocity monitor.
// The input is not ready while a tick is in work, so ticks are taken one at a time.
// Each channel takes 4 steps of the shared subtract/multiply unit, plus a final compare
// state that holds, and with it the input, while the previous result beat waits on m_ready.
// Reset (aresetn low, synchronous): control and configuration registers, previous counts
// and sticky flags cleared; the payload registers are not reset.
module encoder_count_velocity_monitor_top
    import ecvm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data,
    // configuration write port
    input  logic                  cfg_we,
    input  cfg_addr_t             cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_LAST = 2'd2;

    // Per-channel step within ST_RUN
    localparam logic [1:0] PH_JUMP   = 2'd0;  // issue cur - prev
    localparam logic [1:0] PH_TARGET = 2'd1;  // issue cur - target count
    localparam logic [1:0] PH_DEV    = 2'd2;  // issue v - target velocity
    localparam logic [1:0] PH_MUL    = 2'd3;  // issue |t| * limit

    function automatic logic [31:0] abs32(input logic signed [31:0] x);
        logic [31:0] r;
        r = x[31] ? 32'(-x) : 32'(x);
        return r;
    endfunction

    // configuration registers
    logic [3:0]         irq_en_reg;
    logic signed [31:0] tgt_count_reg [2];
    logic signed [31:0] tgt_vel_reg   [2];
    logic [30:0]        limit_reg     [2];

    // control state
    logic [1:0]  state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    logic        m_valid_reg;
    logic [3:0]  flags_reg;       // ov_a, un_a, ov_b, un_b from bit 0
    logic        count_hit_reg;
    logic        vel_hit_reg;
    logic [31:0] prev_reg [2];

    // payload
    logic signed [31:0] cur_reg [2];
    logic [15:0]        vel_reg [2];
    logic [38:0]        dm100_reg;
    out_beat_t          m_data_reg;

    // shared unit
    alu_req_t           alu_req;
    logic [ALU_RES_W-1:0] alu_res;

    logic       ch;
    logic [1:0] phase;
    logic       cmp_ch;
    logic       cmp_en;
    logic       vel_ok;
    logic       out_fire;

    logic signed [31:0] res_s32;
    logic signed [33:0] dev;
    logic [31:0]        dm;
    logic [31:0]        tm_issue;
    logic [31:0]        tm_cmp;
    logic [64:0]        lhs;
    logic [64:0]        rhs;
    logic signed [31:0] vq;

    assign ch    = step_reg[2];
    assign phase = step_reg[1:0];

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign out_fire = (state_reg == ST_LAST) && (!m_valid_reg || m_ready);

    // ---------------- shared unit issue ----------------
    assign vq       = {vel_reg[ch], 16'h0000};
    assign tm_issue = abs32(tgt_vel_reg[ch]);

    always_comb begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {cur_reg[ch][31], cur_reg[ch]};
        alu_req.b  = {prev_reg[ch][31], prev_reg[ch]};
        case (phase)
            PH_JUMP: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {cur_reg[ch][31], cur_reg[ch]};
                alu_req.b  = {prev_reg[ch][31], prev_reg[ch]};
            end
            PH_TARGET: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {cur_reg[ch][31], cur_reg[ch]};
                alu_req.b  = {tgt_count_reg[ch][31], tgt_count_reg[ch]};
            end
            PH_DEV: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {vq[31], vq};
                alu_req.b  = {tgt_vel_reg[ch][31], tgt_vel_reg[ch]};
            end
            PH_MUL: begin
                alu_req.op = ALU_MUL;
                alu_req.a  = {1'b0, tm_issue};
                alu_req.b  = {2'b00, limit_reg[ch]};
            end
            default: begin
                alu_req.op = ALU_SUB;
            end
        endcase
    end

    ecvm_alu u_alu (
        .aclk    (aclk),
        .req     (alu_req),
        .res_reg (alu_res)
    );

    // ---------------- result consumption ----------------
    // Result of the step issued last cycle; low 32 bits wrap like the counts.
    assign res_s32 = alu_res[31:0];
    assign dev     = alu_res[33:0];
    assign dm      = dev[33] ? 32'(-dev) : 32'(dev);

    // Velocity test without a divider:
    //   round(|d| * 100 * 2^16 / |t|) < limit  <=>  2*|d|*6553600 + |t| < 2*|t|*limit
    // A zero target or zero limit makes the right side zero, so the test fails.
    assign cmp_ch = (state_reg == ST_LAST);
    assign cmp_en = ((state_reg == ST_RUN) && (step_reg == 3'd4)) || (state_reg == ST_LAST);
    assign tm_cmp = abs32(tgt_vel_reg[cmp_ch]);
    assign lhs    = 65'({dm100_reg, 17'h00000}) + 65'(tm_cmp);
    assign rhs    = {alu_res, 1'b0};
    assign vel_ok = irq_en_reg[{1'b1, cmp_ch}] && (lhs < rhs);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN: begin
                if (step_reg == 3'd7) begin
                    // step stays on the last multiply so its product holds in ST_LAST
                    state_next = ST_LAST;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_LAST: begin
                if (out_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            m_valid_reg      <= 1'b0;
            flags_reg        <= '0;
            count_hit_reg    <= 1'b0;
            vel_hit_reg      <= 1'b0;
            prev_reg[0]      <= '0;
            prev_reg[1]      <= '0;
            irq_en_reg       <= '0;
            tgt_count_reg[0] <= '0;
            tgt_count_reg[1] <= '0;
            tgt_vel_reg[0]   <= '0;
            tgt_vel_reg[1]   <= '0;
            limit_reg[0]     <= '0;
            limit_reg[1]     <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;

            if (cfg_we) begin
                case (cfg_addr)
                    CFG_IRQ_ENABLES:       irq_en_reg       <= cfg_wdata[3:0];
                    CFG_TARGET_COUNT_A:    tgt_count_reg[0] <= cfg_wdata;
                    CFG_TARGET_COUNT_B:    tgt_count_reg[1] <= cfg_wdata;
                    CFG_TARGET_VELOCITY_A: tgt_vel_reg[0]   <= cfg_wdata;
                    CFG_TARGET_VELOCITY_B: tgt_vel_reg[1]   <= cfg_wdata;
                    CFG_RATIO_LIMIT_A:     limit_reg[0]     <= cfg_wdata[30:0];
                    CFG_RATIO_LIMIT_B:     limit_reg[1]     <= cfg_wdata[30:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                count_hit_reg <= 1'b0;
                vel_hit_reg   <= 1'b0;
            end

            if (state_reg == ST_RUN) begin
                case (phase)
                    PH_TARGET: begin
                        // jump result is back
                        prev_reg[ch] <= cur_reg[ch];
                        if (res_s32 > JUMP_LIMIT) begin
                            flags_reg[{ch, 1'b0}] <= 1'b1;
                        end
                        if (res_s32 < -JUMP_LIMIT) begin
                            flags_reg[{ch, 1'b1}] <= 1'b1;
                        end
                    end
                    PH_DEV: begin
                        // distance to target count is back
                        if (irq_en_reg[{1'b0, ch}] && (res_s32 > -REACH_WINDOW)
                                && (res_s32 < REACH_WINDOW)) begin
                            count_hit_reg <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            if (cmp_en && vel_ok) begin
                vel_hit_reg <= 1'b1;
            end

            if (out_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cur_reg[0] <= s_data.count_a;
            cur_reg[1] <= s_data.count_b;
        end
        if ((state_reg == ST_RUN) && (phase == PH_TARGET)) begin
            vel_reg[ch] <= res_s32[15:0];
        end
        if ((state_reg == ST_RUN) && (phase == PH_MUL)) begin
            // |d| * 100 as shifts and adds
            dm100_reg <= {1'b0, dm, 6'd0} + {2'b00, dm, 5'd0} + {5'd0, dm, 2'd0};
        end
        if (out_fire) begin
            m_data_reg.velocity_a       <= vel_reg[0];
            m_data_reg.velocity_b       <= vel_reg[1];
            m_data_reg.overflow_a       <= flags_reg[0];
            m_data_reg.underflow_a      <= flags_reg[1];
            m_data_reg.overflow_b       <= flags_reg[2];
            m_data_reg.underflow_b      <= flags_reg[3];
            m_data_reg.count_reached    <= count_hit_reg;
            m_data_reg.velocity_reached <= vel_hit_reg || vel_ok;
        end
    end

endmodule

// ===== rtl/ecvm_checker.sv =====
// Port-level checker for the encoder velocity monitor, bound to the top level.
`include "encoder_count_velocity_monitor_top_macros.svh"

module ecvm_checker
    import ecvm_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    logic in_fire;
    logic fire_d [10];

    assign in_fire  = s_valid && s_ready;

    // delay line of input accepts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 10; i++) begin
                fire_d[i] <= 1'b0;
            end
        end else begin
            fire_d[0] <= in_fire;
            for (int i = 1; i < 10; i++) begin
                fire_d[i] <= fire_d[i-1];
            end
        end
    end

    // one tick at a time
    `ECVM_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_ready)

    // a fresh result appears only when the end of the accept delay line shows its tick
    `ECVM_ASSERT_NOW(a_result_latency, m_valid && !$past(m_valid), fire_d[9])

    // stalled result beat holds
    `ECVM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // sticky jump flags overflow_a and underflow_b never drop while the result stays valid
    `ECVM_ASSERT_NEXT(a_sticky_flags, m_valid && (m_data.overflow_a || m_data.underflow_b),
        !m_valid || ((m_data.overflow_a || !$past(m_data.overflow_a))
        && (m_data.underflow_b || !$past(m_data.underflow_b))))

endmodule

bind encoder_count_velocity_monitor_top ecvm_checker u_ecvm_checker (.*);
